// ----- sv/route_point_list_length_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the route point list length block
// Shared property shapes: a clocked implication, same cycle or next cycle,
// both held off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ROUTE_POINT_LIST_LENGTH_ASSERT_SVH
`define ROUTE_POINT_LIST_LENGTH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RPLL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("route point list check failed");

// antecedent implies consequent in the next cycle
`define RPLL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("route point list check failed");

`endif

// ----- sv/rpll_pkg.sv -----
// ---------------------------------------------------------------------------
// rpll_pkg
// Types, sizes and codes shared by the point list cells, the segment length
// unit, the top level and the checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpll_pkg;

	localparam int CAPACITY   = 64;
	localparam int COORD_BITS = 16;

	// stream field widths
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 6;
	localparam int FIELD_W = 16;
	localparam int STAT_W  = 2;
	localparam int PCNT_W  = 7;
	localparam int LEN_W   = 31;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 40;

	// list sizes
	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (IDX_W > CW) ? IDX_W : CW;

	// segment arithmetic
	localparam int MAG_SAT = 24;                       // |d| >= 2^24 saturates
	localparam int MW      = (COORD_BITS < MAG_SAT) ? COORD_BITS : MAG_SAT;
	localparam int SQ_W    = 2 * MW;
	localparam int D2_W    = SQ_W + 1;
	localparam int D2_SAT  = 47;                       // d^2 >= 2^47 saturates
	localparam int DN_W    = (D2_W < D2_SAT) ? D2_W : D2_SAT;
	localparam int FRAC    = 16;                       // radicand scaled by 2^16
	localparam int RW      = (DN_W + FRAC + 1) / 2;    // root bits
	localparam int RAD_W   = 2 * RW;
	localparam int ITW     = $clog2(RW + 1);

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_APPEND = 3'd1,
		CELL_INSERT = 3'd2,
		CELL_DELETE = 3'd3,
		CELL_ROTATE = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pt_t;

	// broadcast to every cell; cnt is the count before the operation
	typedef struct packed {
		cell_op_t        op;
		logic [PW-1:0]   idx;
		logic [CW-1:0]   cnt;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/route_point_list_length.sv -----
// ---------------------------------------------------------------------------
// route_point_list_length
// Ordered list of 2-D points with append, insert, delete and path length.
// ---------------------------------------------------------------------------
// One command beat in, one result beat out. The points sit in a row of
// CAPACITY cells; append, insert and delete update every cell at once and
// then go to the result state. A query rotates the row one slot per
// segment, so cells 0 and 1 always present a consecutive pair, and each
// segment goes through the length unit: magnitude, square and load, then
// one root bit per cycle (25 root bits with 16-bit coordinates). The row
// is then rotated on to a full turn, one slot a cycle. A query on fewer
// than two points goes straight to the result. One command is worked at a
// time; the next is taken while the last result still waits downstream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module route_point_list_length (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rpll_pkg::IN_W-1:0]    s_tdata,   // index[5:0], x_coord[21:6], y_coord[37:22]
	input  logic [rpll_pkg::KIND_W-1:0]  s_tuser,   // kind[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rpll_pkg::OUT_W-1:0]   m_tdata    // status[1:0], point_count[8:2], path_length[39:9]
);
	import rpll_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEG  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_PUT  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rot_q;
	logic [CW-1:0]      segs_q;
	stat_t              status_q;
	logic [LEN_W-1:0]   len_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tvalid_q;

	kind_t              kind;
	logic [IDX_W-1:0]   index_f;
	logic [CMPW-1:0]    idx_ext;
	pt_t                new_pt;
	logic               in_acc;
	logic               out_free;
	logic               full;
	logic               bad_idx;
	logic               multi;

	cell_op_t           acc_op;
	stat_t              acc_stat;
	logic [CW-1:0]      acc_cnt;
	cell_cmd_t          cell_cmd;
	logic               rotate;
	logic               seg_start;
	logic               seg_done;
	logic [LEN_W-1:0]   seg_len;
	logic [LEN_W:0]     len_sum;
	logic [LEN_W-1:0]   acc_len;

	pt_t                pts [CAPACITY];

	assign kind     = kind_t'(s_tuser);
	assign index_f  = s_tdata[IDX_W-1:0];
	assign idx_ext  = CMPW'(index_f);
	assign new_pt.x = COORD_BITS'(32'(s_tdata[IDX_W +: FIELD_W]));
	assign new_pt.y = COORD_BITS'(32'(s_tdata[IDX_W+FIELD_W +: FIELD_W]));

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign bad_idx  = (idx_ext >= CMPW'(count_q));
	assign multi    = (count_q >= CW'(2));

	always_comb begin
		acc_op   = CELL_HOLD;
		acc_stat = STAT_OK;
		acc_cnt  = count_q;
		unique case (kind)
			KIND_APPEND: begin
				if (full) begin
					acc_stat = STAT_FULL;
				end else begin
					acc_op  = CELL_APPEND;
					acc_cnt = count_q + CW'(1);
				end
			end
			KIND_INSERT: begin
				if (full) begin
					acc_stat = STAT_FULL;
				end else if (bad_idx) begin
					acc_stat = STAT_BAD_INDEX;
				end else begin
					acc_op  = CELL_INSERT;
					acc_cnt = count_q + CW'(1);
				end
			end
			KIND_DELETE: begin
				if (bad_idx) begin
					acc_stat = STAT_BAD_INDEX;
				end else begin
					acc_op  = CELL_DELETE;
					acc_cnt = count_q - CW'(1);
				end
			end
			KIND_QUERY: begin
				if (multi)
					acc_op = CELL_ROTATE;
			end
		endcase
	end

	// next segment starts on the beat that finishes the current one
	assign seg_start = (in_acc && kind == KIND_QUERY && multi) ||
		(state_q == ST_SEG && seg_done && segs_q > CW'(1));
	assign rotate = seg_start ||
		(state_q == ST_FIN && rot_q != CW'(CAPACITY));

	always_comb begin
		if (in_acc)
			cell_cmd.op = acc_op;
		else if (rotate)
			cell_cmd.op = CELL_ROTATE;
		else
			cell_cmd.op = CELL_HOLD;
		cell_cmd.idx = idx_ext[PW-1:0];
		cell_cmd.cnt = count_q;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		rpll_cell u_cell (
			.clk     (clk),
			.pos     (PW'(g)),
			.cmd     (cell_cmd),
			.new_pt  (new_pt),
			.prev_pt (pts[(g + CAPACITY - 1) % CAPACITY]),
			.next_pt (pts[(g + 1) % CAPACITY]),
			.pt      (pts[g])
		);
	end

	rpll_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start),
		.a      (pts[0]),
		.b      (pts[1]),
		.done   (seg_done),
		.len    (seg_len)
	);

	assign len_sum = (LEN_W+1)'(len_q) + (LEN_W+1)'(seg_len);
	assign acc_len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rot_q      <= '0;
			segs_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= acc_cnt;
						if (kind == KIND_QUERY && multi) begin
							rot_q   <= CW'(1);
							segs_q  <= count_q - CW'(1);
							state_q <= ST_SEG;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_SEG: begin
					if (seg_done) begin
						if (segs_q > CW'(1)) begin
							segs_q <= segs_q - CW'(1);
							rot_q  <= rot_q + CW'(1);
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					// finish the full turn so slot 0 holds the head again
					if (rot_q == CW'(CAPACITY))
						state_q <= ST_PUT;
					else
						rot_q <= rot_q + CW'(1);
				end
				ST_PUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_PUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= acc_stat;
			len_q    <= '0;
		end else if (state_q == ST_SEG && seg_done) begin
			len_q <= acc_len;
		end
		if (state_q == ST_PUT && out_free)
			m_tdata_q <= {len_q, PCNT_W'(count_q), status_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ----- sv/rpll_cell.sv -----
// ---------------------------------------------------------------------------
// rpll_cell
// One list slot. Holds a point and, on the broadcast command, keeps it,
// loads the new point, or takes its lower or upper neighbor's point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpll_cell (
	input  logic                      clk,
	input  logic [rpll_pkg::PW-1:0]   pos,
	input  rpll_pkg::cell_cmd_t       cmd,
	input  rpll_pkg::pt_t             new_pt,
	input  rpll_pkg::pt_t             prev_pt,
	input  rpll_pkg::pt_t             next_pt,
	output rpll_pkg::pt_t             pt
);
	import rpll_pkg::*;

	pt_t         pt_q;
	logic [CW:0] pos_w;
	logic [CW:0] idx_w;
	logic [CW:0] cnt_w;

	assign pos_w = (CW+1)'(pos);
	assign idx_w = (CW+1)'(cmd.idx);
	assign cnt_w = (CW+1)'(cmd.cnt);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: pt_q <= pt_q;
			CELL_APPEND: begin
				if (pos_w == cnt_w)
					pt_q <= new_pt;
			end
			CELL_INSERT: begin
				if (pos_w == idx_w)
					pt_q <= new_pt;
				else if (pos_w > idx_w && pos_w <= cnt_w)
					pt_q <= prev_pt;
			end
			CELL_DELETE: begin
				if (pos_w >= idx_w && (pos_w + (CW+1)'(1)) < cnt_w)
					pt_q <= next_pt;
			end
			CELL_ROTATE: pt_q <= next_pt;
			default: pt_q <= pt_q;
		endcase
	end

	assign pt = pt_q;

endmodule

`default_nettype wire

// ----- sv/rpll_isqrt.sv -----
// ---------------------------------------------------------------------------
// rpll_isqrt
// Integer square root, restoring digit recurrence, one root bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpll_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rpll_pkg::RAD_W-1:0]  radicand,
	output logic                        done,
	output logic [rpll_pkg::RW-1:0]     root
);
	import rpll_pkg::*;

	logic [RAD_W-1:0] rad_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    root_q;
	logic [ITW-1:0]   iter_q;
	logic             busy_q;
	logic             done_q;

	logic [RW+1:0]    rem_t;
	logic [RW+1:0]    trial;
	logic             ge;

	// remainder stays below 2^RW before the shift, so the top bits drop out
	assign rem_t = {rem_q[RW-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge    = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITW'(RW);
			end else if (busy_q) begin
				iter_q <= iter_q - ITW'(1);
				if (iter_q == ITW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_t - trial) : rem_t;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- sv/rpll_seg.sv -----
// ---------------------------------------------------------------------------
// rpll_seg
// Length of one segment in Q.8: floor(256 * sqrt(dx^2 + dy^2)), saturated.
// Magnitudes, then squares, then the root unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpll_seg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rpll_pkg::pt_t               a,
	input  rpll_pkg::pt_t               b,
	output logic                        done,
	output logic [rpll_pkg::LEN_W-1:0]  len
);
	import rpll_pkg::*;

	logic [COORD_BITS:0]   dfx;
	logic [COORD_BITS:0]   dfy;
	logic [COORD_BITS-1:0] magx;
	logic [COORD_BITS-1:0] magy;
	logic                  big_mag;

	logic                  v_s1;
	logic [MW-1:0]         dx_s1;
	logic [MW-1:0]         dy_s1;
	logic                  big_s1;

	logic                  v_s2;
	logic [SQ_W-1:0]       sqx_s2;
	logic [SQ_W-1:0]       sqy_s2;
	logic                  big_s2;

	logic [D2_W-1:0]       d2;
	logic [RAD_W-1:0]      rad;
	logic                  big_q;
	logic [RW-1:0]         root;

	assign dfx  = (COORD_BITS+1)'(a.x) - (COORD_BITS+1)'(b.x);
	assign dfy  = (COORD_BITS+1)'(a.y) - (COORD_BITS+1)'(b.y);
	assign magx = COORD_BITS'(dfx[COORD_BITS] ? (~dfx + (COORD_BITS+1)'(1)) : dfx);
	assign magy = COORD_BITS'(dfy[COORD_BITS] ? (~dfy + (COORD_BITS+1)'(1)) : dfy);
	assign big_mag = (32'(magx) >= (32'd1 << MAG_SAT)) || (32'(magy) >= (32'd1 << MAG_SAT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_s1  <= MW'(magx);
			dy_s1  <= MW'(magy);
			big_s1 <= big_mag;
		end
		if (v_s1) begin
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			big_s2 <= big_s1;
		end
		if (v_s2)
			big_q <= big_s2 || (64'(d2) >= (64'd1 << D2_SAT));
	end

	assign d2  = D2_W'(sqx_s2) + D2_W'(sqy_s2);
	assign rad = RAD_W'({DN_W'(d2), {FRAC{1'b0}}});

	rpll_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (v_s2),
		.radicand (rad),
		.done     (done),
		.root     (root)
	);

	always_comb begin
		if (big_q || 32'(root) > 32'(LEN_MAX))
			len = LEN_MAX;
		else
			len = LEN_W'(root);
	end

endmodule

`default_nettype wire

// ----- sv/rpll_checker.sv -----
// ---------------------------------------------------------------------------
// rpll_checker
// Port-level checks for the route point list block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "route_point_list_length_assert.svh"

module rpll_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [rpll_pkg::OUT_W-1:0]  m_tdata
);
	import rpll_pkg::*;

	// a stalled result beat keeps its payload
	`RPLL_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// one command at a time: no accept right after an accept
	`RPLL_ASSERT_NXT(a_one_cmd, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// the reported count never exceeds the list size
	`RPLL_ASSERT_IMP(a_count_max, clk, arst_n, m_tvalid, 32'(m_tdata[8:2]) <= 32'(CAPACITY))

	// a nonzero length only comes with a good status
	`RPLL_ASSERT_IMP(a_len_ok, clk, arst_n, m_tvalid && m_tdata[39:9] != '0, m_tdata[1:0] == STAT_OK)

endmodule

bind route_point_list_length rpll_checker u_rpll_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb: route_point_list_length testbench
// Drives append, insert, delete and length query commands into the point
// list and checks every result beat against a shadow copy of the list.
// Coverage comes from a short directed opening and then random fill, drain
// and mixed phases. Both stream sides get random gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import rpll_pkg::*;

	localparam int RANDOM_CMDS = 500;
	localparam int CYCLE_LIMIT = 5_000_000;

	// shadow of the point list; predicts one reply per accepted command
	class path_scoreboard;
		typedef struct {
			stat_t            status;
			logic [CW-1:0]    count;
			logic [LEN_W-1:0] length;
		} reply_t;

		logic signed [COORD_BITS-1:0] xs [CAPACITY];
		logic signed [COORD_BITS-1:0] ys [CAPACITY];
		int unsigned n_points;
		reply_t replies_due [$];
		int unsigned errors;

		function void note_command(kind_t kind, logic [IDX_W-1:0] idx,
				logic signed [COORD_BITS-1:0] px, logic signed [COORD_BITS-1:0] py);
			reply_t r;
			longint ax, ay;
			longint unsigned d2, rad, root, bitv, seg, total;
			int j;
			r.status = STAT_OK;
			total = 0;
			case (kind)
				KIND_APPEND: begin
					if (n_points >= CAPACITY) begin
						r.status = STAT_FULL;
					end else begin
						xs[n_points] = px;
						ys[n_points] = py;
						n_points++;
					end
				end
				KIND_INSERT: begin
					if (n_points >= CAPACITY) begin
						r.status = STAT_FULL;
					end else if (idx >= n_points) begin
						r.status = STAT_BAD_INDEX;
					end else begin
						for (j = n_points; j > idx; j--) begin
							xs[j] = xs[j-1];
							ys[j] = ys[j-1];
						end
						xs[idx] = px;
						ys[idx] = py;
						n_points++;
					end
				end
				KIND_DELETE: begin
					if (idx >= n_points) begin
						r.status = STAT_BAD_INDEX;
					end else begin
						for (j = idx; j + 1 < n_points; j++) begin
							xs[j] = xs[j+1];
							ys[j] = ys[j+1];
						end
						n_points--;
					end
				end
				default: begin
					for (j = 0; j + 1 < n_points; j++) begin
						ax = longint'(xs[j]) - longint'(xs[j+1]);
						ay = longint'(ys[j]) - longint'(ys[j+1]);
						if (ax < 0) ax = -ax;
						if (ay < 0) ay = -ay;
						d2 = ax * ax + ay * ay;
						if (ax >= (64'd1 << 24) || ay >= (64'd1 << 24) || d2 >= (64'd1 << 47)) begin
							seg = LEN_MAX;
						end else begin
							// floor(sqrt(d2 * 2^16)) by the bit-pair method
							rad = d2 << 16;
							root = 0;
							bitv = 64'd1 << 62;
							while (bitv > rad) bitv >>= 2;
							while (bitv != 0) begin
								if (rad >= root + bitv) begin
									rad -= root + bitv;
									root = (root >> 1) + bitv;
								end else begin
									root >>= 1;
								end
								bitv >>= 2;
							end
							seg = (root > LEN_MAX) ? LEN_MAX : root;
						end
						total += seg;
						if (total > LEN_MAX) total = LEN_MAX;
					end
				end
			endcase
			r.count = CW'(n_points);
			r.length = total[LEN_W-1:0];
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [OUT_W-1:0] beat);
			reply_t want;
			stat_t got_status;
			logic [CW-1:0] got_count;
			logic [LEN_W-1:0] got_length;
			got_status = stat_t'(beat[1:0]);
			got_count = beat[8:2];
			got_length = beat[39:9];
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, beat);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got_status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got_status);
				errors++;
			end
			if (got_count !== want.count) begin
				$display("%0t: point_count expected %0d, got %0d", $time, want.count, got_count);
				errors++;
			end
			if (got_length !== want.length) begin
				$display("%0t: path_length expected %0d, got %0d", $time, want.length,
					got_length);
				errors++;
			end
		endfunction
	endclass

	typedef enum {FILLING, DRAINING, MIXING} phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;   // index[5:0], x_coord[21:6], y_coord[37:22]
	logic [KIND_W-1:0]   s_tuser = '0;   // kind[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;        // status[1:0], point_count[8:2], path_length[39:9]

	path_scoreboard board = new();
	bit quiet = 1'b0;
	int unsigned cycles = 0;
	int stall_left = 0;
	phase_t phase = FILLING;
	int bound_hits = 0;
	int mix_left = 0;

	route_point_list_length u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result beat is checked before the command taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_reply(m_tdata);
			if (s_tvalid && s_tready)
				board.note_command(kind_t'(s_tuser), s_tdata[5:0], s_tdata[21:6], s_tdata[37:22]);
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(3) == 0) begin
			stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic signed [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
			2, 3, 4: return 16'($urandom_range(511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// called at a falling edge; holds tvalid high until the beat is taken
	task automatic send_command(kind_t kind, logic [IDX_W-1:0] idx,
			logic signed [COORD_BITS-1:0] px, logic signed [COORD_BITS-1:0] py);
		s_tuser <= kind;
		s_tdata <= {2'b00, py, px, idx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// fill to full, drain to empty, then a mixed stretch, over and over
	task automatic random_command(output kind_t kind, output logic [IDX_W-1:0] idx,
			output logic signed [COORD_BITS-1:0] px, output logic signed [COORD_BITS-1:0] py);
		int unsigned n;
		int r;
		n = board.n_points;
		case (phase)
			FILLING: begin
				if (n == CAPACITY && ++bound_hits >= 4) begin
					phase = DRAINING;
					bound_hits = 0;
				end
			end
			DRAINING: begin
				if (n == 0 && ++bound_hits >= 3) begin
					phase = MIXING;
					bound_hits = 0;
					mix_left = 40;
				end
			end
			default: begin
				if (mix_left == 0) phase = FILLING;
				else mix_left--;
			end
		endcase
		r = $urandom_range(99);
		if (r < 10) kind = KIND_QUERY;
		else if (phase == FILLING) kind = (r < 65) ? KIND_APPEND : (r < 90) ? KIND_INSERT : KIND_DELETE;
		else if (phase == DRAINING) kind = (r < 80) ? KIND_DELETE : (r < 90) ? KIND_INSERT : KIND_APPEND;
		else kind = (r < 40) ? KIND_APPEND : (r < 65) ? KIND_INSERT : KIND_DELETE;
		if ((kind == KIND_INSERT || kind == KIND_DELETE) && n > 0 && $urandom_range(9) != 0)
			idx = IDX_W'($urandom_range(n - 1));
		else
			idx = IDX_W'($urandom);
		px = pick_coord();
		py = pick_coord();
	endtask

	initial begin
		kind_t k;
		logic [IDX_W-1:0] ix;
		logic signed [COORD_BITS-1:0] px, py;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list: query, bad delete, bad insert
		send_command(KIND_QUERY, 6'd17, 16'h1234, 16'h8000);
		send_command(KIND_DELETE, 6'd0, 16'h0000, 16'h0000);
		send_command(KIND_INSERT, 6'd0, 16'h0001, 16'h0001);
		send_command(KIND_APPEND, 6'd63, 16'h8000, 16'h8000);
		send_command(KIND_QUERY, 6'd0, 16'h0000, 16'h0000);
		// insert at the count is not valid
		send_command(KIND_INSERT, 6'd1, 16'h0005, 16'h0005);
		// opposite corners: longest segment
		send_command(KIND_APPEND, 6'd0, 16'h7FFF, 16'h7FFF);
		send_command(KIND_QUERY, 6'd63, 16'h7FFF, 16'h7FFF);
		send_command(KIND_INSERT, 6'd0, 16'h0000, 16'h0000);
		send_command(KIND_INSERT, 6'd2, 16'hFFFF, 16'h0001);
		send_command(KIND_APPEND, 6'd42, 16'h7FFF, 16'h8000);
		send_command(KIND_QUERY, 6'd0, 16'h0000, 16'h0000);
		send_command(KIND_DELETE, 6'd63, 16'h0000, 16'h0000);
		send_command(KIND_DELETE, 6'd4, 16'h0000, 16'h0000);
		send_command(KIND_DELETE, 6'd0, 16'h0000, 16'h0000);
		send_command(KIND_QUERY, 6'd0, 16'h0000, 16'h0000);
		send_command(KIND_INSERT, 6'd1, 16'h8000, 16'h7FFF);
		send_command(KIND_APPEND, 6'd21, 16'h0003, 16'h0004);
		send_command(KIND_QUERY, 6'd0, 16'h0000, 16'h0000);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i % 60 == 0) quiet = ($urandom_range(3) == 0);
			random_command(k, ix, px, py);
			send_command(k, ix, px, py);
			if (!quiet && $urandom_range(2) == 0) begin
				s_tvalid <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (board.replies_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- route_point_list_length.f -----
+incdir+sv
sv/rpll_pkg.sv
sv/rpll_cell.sv
sv/rpll_isqrt.sv
sv/rpll_seg.sv
sv/route_point_list_length.sv
sv/rpll_checker.sv
tb/tb.sv
